[src/linear_probe_id_table_top_assert.svh]
// ----------------------------------------------------------------------------
// linear_probe_id_table_top_assert.svh
// assertion macros shared by the id table checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_ID_TABLE_TOP_ASSERT_SVH
`define LINEAR_PROBE_ID_TABLE_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define LPIT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LPIT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpit_pkg.sv]
// ----------------------------------------------------------------------------
// lpit_pkg
// types and constants of the linear probe id table
// ----------------------------------------------------------------------------
`default_nettype none

package lpit_pkg;

    // default table geometry
    localparam int LPIT_TABLE_SLOTS = 64;
    localparam int LPIT_HANDLER_MAX = 255;

    // field widths fixed by the interface
    localparam int LPIT_ID_W    = 32;
    localparam int LPIT_SLOT_W  = 6;
    localparam int LPIT_COUNT_W = 8;

    // request modes
    localparam logic MODE_LOOKUP   = 1'b0;
    localparam logic MODE_REGISTER = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_ISSUE,
        S_PROBE
    } t_state;

    // request payload
    typedef struct packed {
        logic                 mode;
        logic [LPIT_ID_W-1:0] event_id;
    } t_req;

    // response payload
    typedef struct packed {
        t_status                 status;
        logic [LPIT_SLOT_W-1:0]  slot;
        logic [LPIT_COUNT_W-1:0] handler_count;
    } t_rsp;

endpackage

`default_nettype wire

[src/linear_probe_id_table_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_id_table_top
// open-addressed event id table with linear probing and handler counts
// ----------------------------------------------------------------------------
// sequence: S_IDLE accepts a request, S_HOME finds the home slot (low id
//   bits for power-of-two TABLE_SLOTS, else a serial residue, one id bit a
//   cycle), S_ISSUE issues the first read, then S_PROBE checks the slots
//   in turn; the result lands in the output register after that
// throughput: one request at a time; the single ram read port sets one
//   probed slot per cycle
// reset: clearing zeroes every key and count; requests stall until it ends
`default_nettype none

module linear_probe_id_table_top #(
    parameter int TABLE_SLOTS = lpit_pkg::LPIT_TABLE_SLOTS,
    parameter int HANDLER_MAX = lpit_pkg::LPIT_HANDLER_MAX
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire lpit_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output lpit_pkg::t_rsp     o_rsp
);

    import lpit_pkg::*;

    localparam int SW      = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = LPIT_ID_W + LPIT_COUNT_W;
    localparam bit POW2    = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam int HCAP_I  = (HANDLER_MAX > 255) ? 255 : HANDLER_MAX;
    localparam logic [LPIT_COUNT_W-1:0] HCAP     = LPIT_COUNT_W'(HCAP_I);
    localparam logic [SW-1:0]           LAST_IDX = SW'(TABLE_SLOTS - 1);
    localparam logic [SW:0]             LAST_PRB = (SW + 1)'(TABLE_SLOTS - 1);
    localparam logic [SW:0]             SLOTS_W  = (SW + 1)'(TABLE_SLOTS);
    localparam logic [SW+1:0]           SLOTS_W2 = (SW + 2)'(TABLE_SLOTS);

    // control registers
    t_state                 r_state, n_state;
    logic [SW:0]            r_occ, n_occ;
    logic [SW-1:0]          r_clr, n_clr;
    logic                   r_rsp_valid, n_rsp_valid;

    // working registers
    logic                   r_mode, n_mode;
    logic [LPIT_ID_W-1:0]   r_id, n_id;
    logic [LPIT_ID_W-1:0]   r_shift, n_shift;
    logic [4:0]             r_bitcnt, n_bitcnt;
    logic [SW-1:0]          r_rem, n_rem;
    logic [SW-1:0]          r_idx, n_idx;
    logic [SW:0]            r_probes, n_probes;
    t_rsp                   r_rsp, n_rsp;

    // ram port signals
    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [SW-1:0]          ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;

    // datapath terms
    logic [LPIT_ID_W-1:0]    key;
    logic [LPIT_COUNT_W-1:0] cnt;
    logic                    hit, empty, last, decide, full, out_free;
    logic [SW-1:0]           idx_next;
    logic [SW:0]             rem_try, rem_sub;
    logic [SW-1:0]           rem_next;

    assign key = ram_rdata[ENTRY_W-1:LPIT_COUNT_W];
    assign cnt = ram_rdata[LPIT_COUNT_W-1:0];

    // key and handler count storage
    lpit_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // compare-subtract step of the serial residue
    assign rem_try  = {r_rem, r_shift[LPIT_ID_W-1]};
    assign rem_sub  = rem_try - SLOTS_W;
    assign rem_next = (rem_try >= SLOTS_W) ? rem_sub[SW-1:0] : rem_try[SW-1:0];

    // probe decisions
    assign idx_next = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign hit      = (key == r_id);
    assign empty    = (key == '0);
    assign last     = (r_probes == LAST_PRB);
    assign decide   = hit || empty || last;
    assign full     = {r_occ, 1'b0} >= SLOTS_W2;
    assign out_free = !r_rsp_valid || !i_rsp_stall;

    // sequencer: next state, ram control and result
    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_clr       = r_clr;
        n_mode      = r_mode;
        n_id        = r_id;
        n_shift     = r_shift;
        n_bitcnt    = r_bitcnt;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_probes    = r_probes;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && i_rsp_stall;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = '0;
        ram_raddr   = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_mode   = i_req.mode;
                    n_id     = i_req.event_id;
                    n_shift  = i_req.event_id;
                    n_bitcnt = 5'd31;
                    n_rem    = '0;
                    n_state  = S_HOME;
                end
            end
            S_HOME: begin
                priority if (r_id == '0) begin
                    if (out_free) begin
                        n_rsp       = '{status: ST_INVALID, slot: '0, handler_count: '0};
                        n_rsp_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (POW2) begin
                    n_idx   = r_id[SW-1:0];
                    n_state = S_ISSUE;
                end else begin
                    // one id bit per cycle, msb first
                    n_rem    = rem_next;
                    n_shift  = {r_shift[LPIT_ID_W-2:0], 1'b0};
                    n_bitcnt = r_bitcnt - 1'b1;
                    if (r_bitcnt == 5'd0) begin
                        n_idx   = rem_next;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_probes = '0;
                n_state  = S_PROBE;
            end
            S_PROBE: begin
                if (!decide) begin
                    // read the next slot while this one is checked
                    ram_raddr = idx_next;
                    n_idx     = idx_next;
                    n_probes  = r_probes + 1'b1;
                end else if (out_free) begin
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                    priority if (hit) begin
                        if (r_mode == MODE_LOOKUP) begin
                            n_rsp = '{status: ST_FOUND, slot: LPIT_SLOT_W'(r_idx),
                                      handler_count: cnt};
                        end else if (cnt >= HCAP) begin
                            n_rsp = '{status: ST_SATURATED, slot: LPIT_SLOT_W'(r_idx),
                                      handler_count: cnt};
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {key, cnt + 1'b1};
                            n_rsp     = '{status: ST_FOUND, slot: LPIT_SLOT_W'(r_idx),
                                          handler_count: cnt + 1'b1};
                        end
                    end else if (empty) begin
                        if (r_mode == MODE_LOOKUP) begin
                            n_rsp = '{status: ST_NOT_FOUND, slot: '0, handler_count: '0};
                        end else if (full) begin
                            n_rsp = '{status: ST_FULL, slot: '0, handler_count: '0};
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_id, LPIT_COUNT_W'(1)};
                            n_occ     = r_occ + 1'b1;
                            n_rsp     = '{status: ST_INSERTED, slot: LPIT_SLOT_W'(r_idx),
                                          handler_count: LPIT_COUNT_W'(1)};
                        end
                    end else begin
                        // every slot visited without a match or a hole
                        if (r_mode == MODE_LOOKUP) begin
                            n_rsp = '{status: ST_NOT_FOUND, slot: '0, handler_count: '0};
                        end else begin
                            n_rsp = '{status: ST_FULL, slot: '0, handler_count: '0};
                        end
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_occ       <= '0;
            r_clr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_clr       <= n_clr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // working registers and response payload
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_shift  <= n_shift;
        r_bitcnt <= n_bitcnt;
        r_rem    <= n_rem;
        r_idx    <= n_idx;
        r_probes <= n_probes;
        r_rsp    <= n_rsp;
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

[src/lpit_ram.sv]
// ----------------------------------------------------------------------------
// lpit_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module lpit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/lpit_checker.sv]
// ----------------------------------------------------------------------------
// lpit_checker
// port-level checks on the linear probe id table
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_id_table_top_assert.svh"

module lpit_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_stall,
    input wire logic           o_rsp_valid,
    input wire logic           i_rsp_stall,
    input wire lpit_pkg::t_rsp o_rsp
);

    import lpit_pkg::*;

    logic req_fire;

    assign req_fire = i_req_valid && !o_req_stall;

    // a stalled response holds
    `LPIT_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_rsp), "stalled response changed")

    // an accepted request leaves the block busy in the next cycle
    `LPIT_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, req_fire, o_req_stall, "request taken while still busy")

    // misses, refusals and bad ids carry no slot and no count
    `LPIT_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_rsp_valid && (o_rsp.status == ST_NOT_FOUND || o_rsp.status == ST_FULL || o_rsp.status == ST_INVALID), o_rsp.slot == '0 && o_rsp.handler_count == '0, "miss response with slot or count")

    // a fresh insert starts with one handler
    `LPIT_ASSERT_IMP(a_insert_one, i_clk, i_rst_n, o_rsp_valid && o_rsp.status == ST_INSERTED, o_rsp.handler_count == 8'd1, "insert response count not one")

    // a found or saturated slot always has a handler
    `LPIT_ASSERT_IMP(a_found_nonzero, i_clk, i_rst_n, o_rsp_valid && (o_rsp.status == ST_FOUND || o_rsp.status == ST_SATURATED), o_rsp.handler_count != '0, "found slot with no handler")

endmodule

bind linear_probe_id_table_top lpit_checker u_lpit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire
